// File: hw/rtl/segment_intersection_point_top_defines.svh
// ---------------------------------------------------------------------------
// Segment intersection point: assertion macros
// Shared assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_POINT_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define SPI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spi assertion failed");

// Antecedent implies consequent in the next cycle.
`define SPI_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("spi assertion failed");

`else

`define SPI_ASSERT_SAME(label, clk, rst, ante, cons)
`define SPI_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

// File: hw/rtl/spi_pkg.sv
// ---------------------------------------------------------------------------
// Segment intersection point package
// Widths, orientation codes, transfer structs and small helper functions.
// ---------------------------------------------------------------------------
package spi_pkg;

   // Coordinate width and the widths that follow from it.
   localparam int CW         = 16;
   localparam int DW         = CW + 1;          // coordinate difference
   localparam int PW         = 2 * DW;          // difference product
   localparam int DETW       = PW + 1;          // orientation value, determinant
   localparam int CPW        = DW + CW;         // line constant product
   localparam int CCW        = CPW + 1;         // line constant
   localparam int NPW        = DW + CCW;        // numerator product
   localparam int NUMW       = NPW + 1;         // numerator
   localparam int BPS        = 4;               // quotient bits per divider stage
   localparam int DIV_STAGES = (NUMW + BPS - 1) / BPS;
   localparam int PADW       = DIV_STAGES * BPS;

   // Orientation of an endpoint triple.
   typedef enum logic [1:0] {
      ORI_ZERO = 2'd0,
      ORI_POS  = 2'd1,
      ORI_NEG  = 2'd2
   } ori_type;

   // Geometry stage results handed to the numerator stages.
   typedef struct packed {
      logic                   hit;
      logic signed [DW-1:0]   a1;
      logic signed [DW-1:0]   b1;
      logic signed [DW-1:0]   a2;
      logic signed [DW-1:0]   b2;
      logic signed [CCW-1:0]  c1;
      logic signed [CCW-1:0]  c2;
      logic signed [DETW-1:0] det;
   } geom_type;

   // Unsigned division operands handed to the divider.
   typedef struct packed {
      logic                       hit;
      logic                       pv;
      logic [1:0]                 neg;
      logic [1:0][PADW-1:0]       nmag;
      logic [DETW-1:0]            dmag;
   } div_in_type;

   // Divider results handed to the output register.
   typedef struct packed {
      logic                 hit;
      logic                 pv;
      logic [1:0]           neg;
      logic [1:0][CW-1:0]   quo;
   } div_out_type;

   // Signed difference of two coordinates at full width.
   function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      sdiff = DW'(a) - DW'(b);
   endfunction

   // Orientation code of a signed orientation value.
   function automatic ori_type ori_of(input logic signed [DETW-1:0] v);
      if (v == '0) begin
         ori_of = ORI_ZERO;
      end else if (v[DETW-1]) begin
         ori_of = ORI_NEG;
      end else begin
         ori_of = ORI_POS;
      end
   endfunction

   // True when r lies in the closed range spanned by p and q.
   function automatic logic in_span(input logic signed [CW-1:0] p,
                                    input logic signed [CW-1:0] q,
                                    input logic signed [CW-1:0] r);
      in_span = ((r >= p) && (r <= q)) || ((r >= q) && (r <= p));
   endfunction

endpackage

// File: hw/rtl/spi_geom.sv
// ---------------------------------------------------------------------------
// Segment intersection point: geometry stages
// Three stages: differences and box tests, products, orientations and hit.
// ---------------------------------------------------------------------------
module spi_geom import spi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] ax,
   input  logic signed [CW-1:0] ay,
   input  logic signed [CW-1:0] bx,
   input  logic signed [CW-1:0] by,
   input  logic signed [CW-1:0] cx,
   input  logic signed [CW-1:0] cy,
   input  logic signed [CW-1:0] dx,
   input  logic signed [CW-1:0] dy,
   output logic                 out_valid,
   output geom_type             out_data
);

   logic [2:0] valid_ff;

   // Stage one registers.
   logic signed [DW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [DW-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [DW-1:0] e3x_ff, e3y_ff, e4x_ff, e4y_ff;
   logic signed [CW-1:0] ax_ff, ay_ff, cx_ff, cy_ff;
   logic [3:0]           span_ff;

   // Stage two registers.
   logic signed [PW-1:0]  p1a_ff, p1b_ff, p2a_ff, p2b_ff;
   logic signed [PW-1:0]  p3a_ff, p3b_ff, p4a_ff, p4b_ff;
   logic signed [PW-1:0]  pda_ff, pdb_ff;
   logic signed [CPW-1:0] c1a_ff, c1b_ff, c2a_ff, c2b_ff;
   logic signed [DW-1:0]  a1_2_ff, b1_2_ff, a2_2_ff, b2_2_ff;
   logic [3:0]            span_2_ff;

   // Stage three register.
   geom_type              out_ff;
   geom_type              out_in;

   logic signed [DETW-1:0] o1_val, o2_val, o3_val, o4_val;
   ori_type                o1, o2, o3, o4;

   // Valid bits move with the data whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // Stage one: coordinate differences and bounding-box tests.
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff   <= sdiff(by, ay);
         b1_ff   <= sdiff(ax, bx);
         a2_ff   <= sdiff(dy, cy);
         b2_ff   <= sdiff(cx, dx);
         e1x_ff  <= sdiff(cx, bx);
         e1y_ff  <= sdiff(cy, by);
         e2x_ff  <= sdiff(dx, bx);
         e2y_ff  <= sdiff(dy, by);
         e3x_ff  <= sdiff(ax, dx);
         e3y_ff  <= sdiff(ay, dy);
         e4x_ff  <= sdiff(bx, dx);
         e4y_ff  <= sdiff(by, dy);
         ax_ff   <= ax;
         ay_ff   <= ay;
         cx_ff   <= cx;
         cy_ff   <= cy;
         span_ff <= {in_span(cx, dx, bx) && in_span(cy, dy, by),
                     in_span(cx, dx, ax) && in_span(cy, dy, ay),
                     in_span(ax, bx, dx) && in_span(ay, by, dy),
                     in_span(ax, bx, cx) && in_span(ay, by, cy)};
      end
   end

   // Stage two: orientation, line constant and determinant products.
   always_ff @(posedge clock) begin
      if (adv) begin
         p1a_ff    <= PW'(a1_ff) * PW'(e1x_ff);
         p1b_ff    <= PW'(b1_ff) * PW'(e1y_ff);
         p2a_ff    <= PW'(a1_ff) * PW'(e2x_ff);
         p2b_ff    <= PW'(b1_ff) * PW'(e2y_ff);
         p3a_ff    <= PW'(a2_ff) * PW'(e3x_ff);
         p3b_ff    <= PW'(b2_ff) * PW'(e3y_ff);
         p4a_ff    <= PW'(a2_ff) * PW'(e4x_ff);
         p4b_ff    <= PW'(b2_ff) * PW'(e4y_ff);
         pda_ff    <= PW'(a1_ff) * PW'(b2_ff);
         pdb_ff    <= PW'(a2_ff) * PW'(b1_ff);
         c1a_ff    <= CPW'(a1_ff) * CPW'(ax_ff);
         c1b_ff    <= CPW'(b1_ff) * CPW'(ay_ff);
         c2a_ff    <= CPW'(a2_ff) * CPW'(cx_ff);
         c2b_ff    <= CPW'(b2_ff) * CPW'(cy_ff);
         a1_2_ff   <= a1_ff;
         b1_2_ff   <= b1_ff;
         a2_2_ff   <= a2_ff;
         b2_2_ff   <= b2_ff;
         span_2_ff <= span_ff;
      end
   end

   // Stage three: orientation signs and the crossing decision.
   always_comb begin
      o1_val = DETW'(p1a_ff) + DETW'(p1b_ff);
      o2_val = DETW'(p2a_ff) + DETW'(p2b_ff);
      o3_val = DETW'(p3a_ff) + DETW'(p3b_ff);
      o4_val = DETW'(p4a_ff) + DETW'(p4b_ff);
      o1     = ori_of(o1_val);
      o2     = ori_of(o2_val);
      o3     = ori_of(o3_val);
      o4     = ori_of(o4_val);

      out_in.hit = ((o1 != o2) && (o3 != o4)) ||
                   ((o1 == ORI_ZERO) && span_2_ff[0]) ||
                   ((o2 == ORI_ZERO) && span_2_ff[1]) ||
                   ((o3 == ORI_ZERO) && span_2_ff[2]) ||
                   ((o4 == ORI_ZERO) && span_2_ff[3]);
      out_in.a1  = a1_2_ff;
      out_in.b1  = b1_2_ff;
      out_in.a2  = a2_2_ff;
      out_in.b2  = b2_2_ff;
      out_in.c1  = CCW'(c1a_ff) + CCW'(c1b_ff);
      out_in.c2  = CCW'(c2a_ff) + CCW'(c2b_ff);
      out_in.det = DETW'(pda_ff) - DETW'(pdb_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

// File: hw/rtl/spi_numer.sv
// ---------------------------------------------------------------------------
// Segment intersection point: numerator stages
// Three stages: Cramer products, numerators, magnitudes and quotient signs.
// ---------------------------------------------------------------------------
module spi_numer import spi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  geom_type   in_data,
   output logic       out_valid,
   output div_in_type out_data
);

   logic [2:0] valid_ff;

   logic signed [DW-1:0]   a1, b1, a2, b2;
   logic signed [CCW-1:0]  c1, c2;

   // Stage one registers.
   logic signed [NPW-1:0]  xa_ff, xb_ff, ya_ff, yb_ff;
   logic signed [DETW-1:0] det_ff;
   logic                   hit_ff;

   // Stage two registers.
   logic signed [NUMW-1:0] nx_ff, ny_ff;
   logic signed [DETW-1:0] det_2_ff;
   logic                   hit_2_ff;
   logic                   pv_ff;

   // Stage three register.
   div_in_type             out_ff;
   div_in_type             out_in;

   logic [NUMW-1:0]        nx_mag, ny_mag;

   assign a1 = in_data.a1;
   assign b1 = in_data.b1;
   assign a2 = in_data.a2;
   assign b2 = in_data.b2;
   assign c1 = in_data.c1;
   assign c2 = in_data.c2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // Stage one: the four numerator products.
   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff  <= NPW'(b2) * NPW'(c1);
         xb_ff  <= NPW'(b1) * NPW'(c2);
         ya_ff  <= NPW'(a1) * NPW'(c2);
         yb_ff  <= NPW'(a2) * NPW'(c1);
         det_ff <= in_data.det;
         hit_ff <= in_data.hit;
      end
   end

   // Stage two: numerators and the point flag.
   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff    <= NUMW'(xa_ff) - NUMW'(xb_ff);
         ny_ff    <= NUMW'(ya_ff) - NUMW'(yb_ff);
         det_2_ff <= det_ff;
         hit_2_ff <= hit_ff;
         pv_ff    <= hit_ff && (det_ff != '0);
      end
   end

   // Stage three: magnitudes and signs of the quotients.
   always_comb begin
      nx_mag         = nx_ff[NUMW-1] ? (~nx_ff + 1'b1) : nx_ff;
      ny_mag         = ny_ff[NUMW-1] ? (~ny_ff + 1'b1) : ny_ff;
      out_in.hit     = hit_2_ff;
      out_in.pv      = pv_ff;
      out_in.neg[0]  = nx_ff[NUMW-1] ^ det_2_ff[DETW-1];
      out_in.neg[1]  = ny_ff[NUMW-1] ^ det_2_ff[DETW-1];
      out_in.nmag[0] = PADW'(nx_mag);
      out_in.nmag[1] = PADW'(ny_mag);
      out_in.dmag    = det_2_ff[DETW-1] ? (~det_2_ff + 1'b1) : det_2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

// File: hw/rtl/spi_div.sv
// ---------------------------------------------------------------------------
// Segment intersection point: pipelined divider
// Restoring division of both numerators, BPS (four) quotient bits per stage.
// ---------------------------------------------------------------------------
module spi_div import spi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_in_type  in_data,
   output logic        out_valid,
   output div_out_type out_data
);

   // Per-stage working set for both lanes.
   typedef struct packed {
      logic                  hit;
      logic                  pv;
      logic [1:0]            neg;
      logic [DETW-1:0]       dmag;
      logic [1:0][PADW-1:0]  num;
      logic [1:0][DETW-1:0]  rem;
      logic [1:0][CW-1:0]    quo;
   } work_type;

   logic [DIV_STAGES-1:0] valid_ff;
   work_type              work_ff [DIV_STAGES];
   work_type              seed;

   // The first stage starts from a clear remainder and quotient.
   always_comb begin
      seed.hit  = in_data.hit;
      seed.pv   = in_data.pv;
      seed.neg  = in_data.neg;
      seed.dmag = in_data.dmag;
      seed.num  = in_data.nmag;
      seed.rem  = '0;
      seed.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      work_type w_prev;
      work_type w_in;

      if (s == 0) begin : g_first
         assign w_prev = seed;
      end else begin : g_next
         assign w_prev = work_ff[s-1];
      end

      // Shift in one numerator bit and try a subtraction, per quotient bit.
      always_comb begin
         logic [DETW:0] trial;
         w_in = w_prev;
         for (int ln = 0; ln < 2; ln++) begin
            for (int b = 0; b < BPS; b++) begin
               trial       = {w_in.rem[ln], w_in.num[ln][PADW-1]};
               w_in.num[ln] = {w_in.num[ln][PADW-2:0], 1'b0};
               if (trial >= {1'b0, w_in.dmag}) begin
                  trial        = trial - {1'b0, w_in.dmag};
                  w_in.quo[ln] = {w_in.quo[ln][CW-2:0], 1'b1};
               end else begin
                  w_in.quo[ln] = {w_in.quo[ln][CW-2:0], 1'b0};
               end
               w_in.rem[ln] = trial[DETW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            work_ff[s] <= w_in;
         end
      end
   end

   assign out_valid     = valid_ff[DIV_STAGES-1];
   assign out_data.hit  = work_ff[DIV_STAGES-1].hit;
   assign out_data.pv   = work_ff[DIV_STAGES-1].pv;
   assign out_data.neg  = work_ff[DIV_STAGES-1].neg;
   assign out_data.quo  = work_ff[DIV_STAGES-1].quo;

endmodule

// File: hw/rtl/segment_intersection_point_top.sv
// ---------------------------------------------------------------------------
// Segment intersection point
// Orientation test of two segments with the Cramer intersection point.
// ---------------------------------------------------------------------------
//  Channel  Handshake          Contents
//  req      req_valid/stall    endpoints p1, q1, p2, q2
//  rsp      rsp_valid/stall    segments_cross, point_valid, cross_x, cross_y
//
// One pair is accepted per cycle unless the pipeline is stalled; each result passes
// through 3 geometry, 3 numerator and 13 divider stages and 1 output register.
// The divider stage count, and so the latency, is set by the numerator width.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result holds the whole pipeline, so nothing is lost or repeated.
`include "segment_intersection_point_top_defines.svh"

module segment_intersection_point_top import spi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [CW-1:0] req_p1_x,
   input  logic signed [CW-1:0] req_p1_y,
   input  logic signed [CW-1:0] req_q1_x,
   input  logic signed [CW-1:0] req_q1_y,
   input  logic signed [CW-1:0] req_p2_x,
   input  logic signed [CW-1:0] req_p2_y,
   input  logic signed [CW-1:0] req_q2_x,
   input  logic signed [CW-1:0] req_q2_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_segments_cross,
   output logic                 rsp_point_valid,
   output logic signed [CW-1:0] rsp_cross_x,
   output logic signed [CW-1:0] rsp_cross_y
);

   logic        adv;
   logic        geom_valid, numer_valid, div_valid;
   geom_type    geom_data;
   div_in_type  numer_data;
   div_out_type div_data;

   logic                 valid_ff;
   logic                 cross_ff, point_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [CW-1:0] x_in, y_in;

   // The pipeline moves whenever the output register is free or drained.
   assign adv       = !valid_ff || !rsp_stall;
   assign req_stall = !adv;

   spi_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .ax        (req_p1_x),
      .ay        (req_p1_y),
      .bx        (req_q1_x),
      .by        (req_q1_y),
      .cx        (req_p2_x),
      .cy        (req_p2_y),
      .dx        (req_q2_x),
      .dy        (req_q2_y),
      .out_valid (geom_valid),
      .out_data  (geom_data)
   );

   spi_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (geom_valid),
      .in_data   (geom_data),
      .out_valid (numer_valid),
      .out_data  (numer_data)
   );

   spi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (numer_valid),
      .in_data   (numer_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // Apply the quotient signs and zero the point when it is not valid.
   always_comb begin
      x_in = '0;
      y_in = '0;
      if (div_data.pv) begin
         x_in = div_data.neg[0] ? (~div_data.quo[0] + 1'b1) : div_data.quo[0];
         y_in = div_data.neg[1] ? (~div_data.quo[1] + 1'b1) : div_data.quo[1];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cross_ff <= div_data.hit;
         point_ff <= div_data.pv;
         x_ff     <= x_in;
         y_ff     <= y_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_segments_cross = cross_ff;
   assign rsp_point_valid    = point_ff;
   assign rsp_cross_x        = x_ff;
   assign rsp_cross_y        = y_ff;

   // A point is only reported for segments that cross.
   `SPI_ASSERT_SAME(a_point_needs_cross, clock, reset, rsp_valid && rsp_point_valid, rsp_segments_cross)
   // Without a point both coordinates read zero.
   `SPI_ASSERT_SAME(a_no_point_zero, clock, reset, rsp_valid && !rsp_point_valid, (rsp_cross_x == '0) && (rsp_cross_y == '0))
   // Reset empties the pipeline, so no result follows it directly.
   `SPI_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && !u_div.out_valid)

endmodule

// File: tb/sv/tb_segment_intersection_point_top.sv
// ---------------------------------------------------------------------------
// Segment intersection point testbench
// Drives segment pairs through the valid/stall request channel, predicts
// the crossing flags and the truncated intersection point at full width,
// and compares each response transaction with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_segment_intersection_point_top import spi_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM = 1830;
   localparam int LATENCY    = 20;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y;
   } seg_pair_type;

   typedef struct packed {
      logic      crosses;
      logic      has_point;
      coord_type px;
      coord_type py;
   } crossing_type;

   // Directed stimulus row: a pair, and optionally a typed-in result.
   typedef struct packed {
      seg_pair_type pair;
      logic         fixed;
      crossing_type result;
   } directed_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_p1_x = '0, req_p1_y = '0, req_q1_x = '0, req_q1_y = '0;
   coord_type req_p2_x = '0, req_p2_y = '0, req_q2_x = '0, req_q2_y = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_segments_cross;
   logic      rsp_point_valid;
   coord_type rsp_cross_x;
   coord_type rsp_cross_y;

   crossing_type expected_crossings[$];
   int           failures = 0;
   int           results_seen = 0;
   int           hits_seen = 0;
   int           points_seen = 0;
   bit           quiet_stretch = 1'b0;

   segment_intersection_point_top u_dut (.*);

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Orientation sign of r against the directed line p->q.
   function automatic ori_type orientation(longint px, longint py, longint qx,
                                           longint qy, longint rx, longint ry);
      longint v;
      v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      if (v == 0) begin
         return ORI_ZERO;
      end
      return (v > 0) ? ORI_POS : ORI_NEG;
   endfunction

   // True when r lies in the bounding box of p and q.
   function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
      return rx >= ((px < qx) ? px : qx) && rx <= ((px < qx) ? qx : px) &&
             ry >= ((py < qy) ? py : qy) && ry <= ((py < qy) ? qy : py);
   endfunction

   // Crossing test and Cramer point, quotient truncated toward zero.
   function automatic crossing_type predict_crossing(seg_pair_type s);
      longint       ax, ay, bx, by, cx, cy, dx, dy;
      longint       a1, b1, c1, a2, b2, c2, det;
      logic signed [127:0] nx, ny, qx, qy;
      ori_type      o1, o2, o3, o4;
      crossing_type r;
      ax = s.p1x; ay = s.p1y; bx = s.q1x; by = s.q1y;
      cx = s.p2x; cy = s.p2y; dx = s.q2x; dy = s.q2y;
      o1 = orientation(ax, ay, bx, by, cx, cy);
      o2 = orientation(ax, ay, bx, by, dx, dy);
      o3 = orientation(cx, cy, dx, dy, ax, ay);
      o4 = orientation(cx, cy, dx, dy, bx, by);
      r = '0;
      r.crosses = (o1 != o2 && o3 != o4) ||
                  (o1 == ORI_ZERO && in_box(ax, ay, bx, by, cx, cy)) ||
                  (o2 == ORI_ZERO && in_box(ax, ay, bx, by, dx, dy)) ||
                  (o3 == ORI_ZERO && in_box(cx, cy, dx, dy, ax, ay)) ||
                  (o4 == ORI_ZERO && in_box(cx, cy, dx, dy, bx, by));
      if (r.crosses) begin
         a1 = by - ay; b1 = ax - bx; c1 = a1 * ax + b1 * ay;
         a2 = dy - cy; b2 = cx - dx; c2 = a2 * cx + b2 * cy;
         det = a1 * b2 - a2 * b1;
         if (det != 0) begin
            nx = 128'(b2) * 128'(c1) - 128'(b1) * 128'(c2);
            ny = 128'(a1) * 128'(c2) - 128'(a2) * 128'(c1);
            qx = nx / 128'(det);
            qy = ny / 128'(det);
            r.has_point = 1'b1;
            r.px = qx[CW-1:0];
            r.py = qy[CW-1:0];
         end
      end
      return r;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0:       return coord_type'($urandom);
         1:       return coord_type'($urandom_range(0, 20) - 10);
         default: return coord_type'($urandom_range(0, 2000) - 1000);
      endcase
   endfunction

   // Mostly small grids so that crossings, touches and collinear cases are common.
   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int           mode;
      mode = $urandom_range(0, 3);
      s.p1x = rand_coord(mode); s.p1y = rand_coord(mode);
      s.q1x = rand_coord(mode); s.q1y = rand_coord(mode);
      s.p2x = rand_coord(mode); s.p2y = rand_coord(mode);
      s.q2x = rand_coord(mode); s.q2y = rand_coord(mode);
      case ($urandom_range(0, 9))
         0: begin
            // Second segment on the same line as the first.
            s.p2x = s.p1x + 2 * (s.q1x - s.p1x);
            s.p2y = s.p1y + 2 * (s.q1y - s.p1y);
            s.q2x = s.q1x; s.q2y = s.q1y;
         end
         1: begin
            // Degenerate second segment.
            s.q2x = s.p2x; s.q2y = s.p2y;
         end
         2: begin
            // Shared endpoint.
            s.p2x = s.q1x; s.p2y = s.q1y;
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic send_pair(seg_pair_type s);
      req_valid <= 1'b1;
      req_p1_x <= s.p1x; req_p1_y <= s.p1y; req_q1_x <= s.q1x; req_q1_y <= s.q1y;
      req_p2_x <= s.p2x; req_p2_y <= s.p2y; req_q2_x <= s.q2x; req_q2_y <= s.q2y;
      expected_crossings.push_back(predict_crossing(s));
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (!quiet_stretch && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   // Receiver stall, changed at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < 30);
   end

   // Response checker, sampled at the rising edge.
   always @(posedge clock) begin
      crossing_type exp_c;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_crossings.size() == 0) begin
            $error("response transaction with no prediction pending");
            failures++;
         end else begin
            exp_c = expected_crossings.pop_front();
            results_seen++;
            hits_seen += rsp_segments_cross;
            points_seen += rsp_point_valid;
            if (rsp_segments_cross !== exp_c.crosses) begin
               $error("segments_cross: expected %0d, got %0d",
                      exp_c.crosses, rsp_segments_cross);
               failures++;
            end
            if (rsp_point_valid !== exp_c.has_point) begin
               $error("point_valid: expected %0d, got %0d",
                      exp_c.has_point, rsp_point_valid);
               failures++;
            end
            if (rsp_cross_x !== exp_c.px) begin
               $error("cross_x: expected %0d, got %0d", exp_c.px, rsp_cross_x);
               failures++;
            end
            if (rsp_cross_y !== exp_c.py) begin
               $error("cross_y: expected %0d, got %0d", exp_c.py, rsp_cross_y);
               failures++;
            end
         end
      end
   end

   // Directed pairs: extremes, every special case; simple results typed in.
   localparam coord_type MN = coord_type'(16'sh8000);
   localparam coord_type MX = coord_type'(16'sh7fff);
   localparam crossing_type NO_HIT = '0;
   localparam directed_row_type DIRECTED[15] = '{
      // Plain X crossing at the origin.
      '{'{-16'sd4, -16'sd4, 16'sd4, 16'sd4, -16'sd4, 16'sd4, 16'sd4, -16'sd4},
        1'b1, '{1'b1, 1'b1, 16'sd0, 16'sd0}},
      // Disjoint, not parallel.
      '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd5, 16'sd5, 16'sd6, 16'sd9},
        1'b1, NO_HIT},
      // Parallel, apart.
      '{'{16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd1, 16'sd5, 16'sd1},
        1'b1, NO_HIT},
      // Collinear overlap: crosses, no point.
      '{'{16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd3, 16'sd0, 16'sd9, 16'sd0},
        1'b1, '{1'b1, 1'b0, 16'sd0, 16'sd0}},
      // Collinear and disjoint.
      '{'{16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd3, 16'sd3, 16'sd5, 16'sd5},
        1'b1, NO_HIT},
      // Both degenerate, same point.
      '{'{16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7},
        1'b1, '{1'b1, 1'b0, 16'sd0, 16'sd0}},
      // Degenerate point on the other segment.
      '{'{16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd4, 16'sd4},
        1'b1, '{1'b1, 1'b0, 16'sd0, 16'sd0}},
      // T touch at an endpoint.
      '{'{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd2, 16'sd0, 16'sd2, 16'sd5},
        1'b1, '{1'b1, 1'b1, 16'sd2, 16'sd0}},
      // Non-integer point, truncated toward zero (predicted).
      '{'{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd1, 16'sd3, -16'sd1},
        1'b0, NO_HIT},
      '{'{16'sd0, 16'sd0, -16'sd3, -16'sd1, 16'sd0, -16'sd1, -16'sd3, 16'sd1},
        1'b0, NO_HIT},
      // Full-range diagonals.
      '{'{MN, MN, MX, MX, MN, MX, MX, MN}, 1'b0, NO_HIT},
      '{'{MX, MN, MN, MX, MN, MN, MX, MX}, 1'b0, NO_HIT},
      // Extreme box edges, the first collinear along x.
      '{'{MN, MN, MX, MN, MX, MN, MN, MN}, 1'b1, '{1'b1, 1'b0, 16'sd0, 16'sd0}},
      '{'{MX, MX, MX, MX, MN, MN, MN, MN}, 1'b1, NO_HIT},
      '{'{MN, 16'sd0, MX, 16'sd1, 16'sd0, MN, 16'sd1, MX}, 1'b0, NO_HIT}
   };

   // Stimulus.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].fixed && predict_crossing(DIRECTED[i].pair) !== DIRECTED[i].result)
         begin
            $error("directed row %0d: typed-in result disagrees with prediction", i);
            failures++;
         end
         send_pair(DIRECTED[i].pair);
      end
      for (int n = 0; n < NUM_RANDOM; n++) begin
         quiet_stretch = (n >= 600 && n < 800);
         send_pair(random_pair());
      end
      quiet_stretch = 1'b0;
      req_valid <= 1'b0;
      wait (expected_crossings.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
      $display("Ran %0d segment pairs: %0d crossing, %0d with an intersection point.",
               results_seen, hits_seen, points_seen);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #400us;
      $display("Verification failed");
      $finish;
   end
endmodule
